FILE: design/lcpfe_pkg.sv
// Shared constants, codes and types for the LED chain PWM frame encoder.
// No dependencies; used by the interfaces and by every module of the block.
`timescale 1ns / 1ps

package lcpfe_pkg;

   // Chain geometry
   localparam int CHAIN_LENGTH   = 16;
   localparam int BITS_PER_PIXEL = 24;
   localparam int TOP_BIT        = 7;
   localparam int PIX_IDX_WIDTH  = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
   localparam int BIT_CNT_WIDTH  = $clog2(BITS_PER_PIXEL);

   // Field widths
   localparam int MODE_WIDTH  = 2;
   localparam int COLOR_WIDTH = TOP_BIT + 1;
   localparam int INDEX_WIDTH = 8;
   localparam int DUTY_WIDTH  = 16;
   localparam int PAD_WIDTH   = 8;

   // Input transaction modes
   localparam logic [MODE_WIDTH-1:0] MODE_WRITE_ONE = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_WRITE_ALL = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_START     = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_TICK      = 2'd3;

   // Register file
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ONE_BIT_DUTY  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ZERO_BIT_DUTY = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RESET_SLOTS   = 2'd2;

   localparam logic [DUTY_WIDTH-1:0] ONE_BIT_DUTY_RESET  = 16'd167;
   localparam logic [DUTY_WIDTH-1:0] ZERO_BIT_DUTY_RESET = 16'd84;
   localparam logic [PAD_WIDTH-1:0]  RESET_SLOTS_RESET   = 8'd50;

   // Controller to datapath
   typedef struct packed {
      logic                     store_write_one;
      logic                     store_write_all;
      logic                     frame_start;
      logic                     out_load;
      logic                     out_zero;
      logic                     out_last;
      logic [PIX_IDX_WIDTH-1:0] pix_sel;
      logic [BIT_CNT_WIDTH-1:0] bit_sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [PAD_WIDTH-1:0] cfg_pad;
      logic [PAD_WIDTH-1:0] frame_pad;
   } sts_type;

endpackage

FILE: design/lcpfe_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on lcpfe_pkg for field widths.
`timescale 1ns / 1ps

interface lcpfe_req_if;
   logic                               valid;
   logic                               ready;
   logic [lcpfe_pkg::MODE_WIDTH-1:0]   mode;
   logic [lcpfe_pkg::INDEX_WIDTH-1:0]  pixel_index;
   logic [lcpfe_pkg::COLOR_WIDTH-1:0]  red;
   logic [lcpfe_pkg::COLOR_WIDTH-1:0]  green;
   logic [lcpfe_pkg::COLOR_WIDTH-1:0]  blue;

   modport source (output valid, mode, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, mode, pixel_index, red, green, blue, output ready);
endinterface

interface lcpfe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lcpfe_pkg::DUTY_WIDTH-1:0]  duty;
   logic                              last_slot;

   modport source (output valid, duty, last_slot, input ready);
   modport sink   (input valid, duty, last_slot, output ready);
endinterface

FILE: design/lcpfe_ctrl.sv
// Frame sequencer: lead pad, pixel data, trail pad; handshake and output valid.
// Depends on lcpfe_pkg; drives lcpfe_datapath through cmd_type.
`timescale 1ns / 1ps

module lcpfe_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [lcpfe_pkg::MODE_WIDTH-1:0] req_mode,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  lcpfe_pkg::sts_type               sts,
   output lcpfe_pkg::cmd_type               cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LEAD  = 2'd1;
   localparam logic [1:0] ST_DATA  = 2'd2;
   localparam logic [1:0] ST_TRAIL = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [lcpfe_pkg::PAD_WIDTH-1:0]     pad_cnt_ff, pad_cnt_in;
   logic [lcpfe_pkg::PIX_IDX_WIDTH-1:0] pix_cnt_ff, pix_cnt_in;
   logic [lcpfe_pkg::BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                accept;
   logic                                pad_end;
   logic                                bit_end;
   logic                                pix_end;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   assign pad_end = ({1'b0, pad_cnt_ff} + 9'd1) == {1'b0, sts.frame_pad};
   assign bit_end = bit_cnt_ff == lcpfe_pkg::BIT_CNT_WIDTH'(lcpfe_pkg::BITS_PER_PIXEL - 1);
   assign pix_end = pix_cnt_ff == lcpfe_pkg::PIX_IDX_WIDTH'(lcpfe_pkg::CHAIN_LENGTH - 1);

   always_comb begin
      state_in   = state_ff;
      pad_cnt_in = pad_cnt_ff;
      pix_cnt_in = pix_cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      cmd.pix_sel = pix_cnt_ff;
      cmd.bit_sel = bit_cnt_ff;

      if (accept) begin
         case (req_mode)
            lcpfe_pkg::MODE_WRITE_ONE: begin
               cmd.store_write_one = (state_ff == ST_IDLE);
            end
            lcpfe_pkg::MODE_WRITE_ALL: begin
               cmd.store_write_all = (state_ff == ST_IDLE);
            end
            lcpfe_pkg::MODE_START: begin
               cmd.frame_start = 1'b1;
               pad_cnt_in = '0;
               pix_cnt_in = '0;
               bit_cnt_in = '0;
               state_in   = (sts.cfg_pad == '0) ? ST_DATA : ST_LEAD;
            end
            lcpfe_pkg::MODE_TICK: begin
               case (state_ff)
                  ST_LEAD: begin
                     cmd.out_load = 1'b1;
                     cmd.out_zero = 1'b1;
                     if (pad_end) begin
                        pad_cnt_in = '0;
                        state_in   = ST_DATA;
                     end else begin
                        pad_cnt_in = pad_cnt_ff + 1'b1;
                     end
                  end
                  ST_DATA: begin
                     cmd.out_load = 1'b1;
                     if (bit_end) begin
                        bit_cnt_in = '0;
                        if (pix_end) begin
                           pix_cnt_in = '0;
                           if (sts.frame_pad == '0) begin
                              cmd.out_last = 1'b1;
                              state_in     = ST_IDLE;
                           end else begin
                              state_in = ST_TRAIL;
                           end
                        end else begin
                           pix_cnt_in = pix_cnt_ff + 1'b1;
                        end
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 1'b1;
                     end
                  end
                  ST_TRAIL: begin
                     cmd.out_load = 1'b1;
                     cmd.out_zero = 1'b1;
                     if (pad_end) begin
                        cmd.out_last = 1'b1;
                        pad_cnt_in   = '0;
                        state_in     = ST_IDLE;
                     end else begin
                        pad_cnt_in = pad_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                     // idle tick: no slot
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_cnt_ff   <= '0;
         pix_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_cnt_ff   <= pad_cnt_in;
         pix_cnt_ff   <= pix_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/lcpfe_datapath.sv
// Pixel store, register file, frame snapshot and slot output register.
// Depends on lcpfe_pkg; commanded by lcpfe_ctrl.
`timescale 1ns / 1ps

module lcpfe_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcpfe_pkg::cmd_type                   cmd,
   output lcpfe_pkg::sts_type                   sts,
   input  logic [lcpfe_pkg::INDEX_WIDTH-1:0]    req_pixel_index,
   input  logic [lcpfe_pkg::COLOR_WIDTH-1:0]    req_red,
   input  logic [lcpfe_pkg::COLOR_WIDTH-1:0]    req_green,
   input  logic [lcpfe_pkg::COLOR_WIDTH-1:0]    req_blue,
   output logic [lcpfe_pkg::DUTY_WIDTH-1:0]     rsp_duty,
   output logic                                 rsp_last_slot,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lcpfe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lcpfe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lcpfe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata
);

   logic [lcpfe_pkg::BITS_PER_PIXEL-1:0] store_ff [lcpfe_pkg::CHAIN_LENGTH];
   logic [lcpfe_pkg::DUTY_WIDTH-1:0]     one_duty_ff, zero_duty_ff;
   logic [lcpfe_pkg::PAD_WIDTH-1:0]      pad_ff;
   logic [lcpfe_pkg::DUTY_WIDTH-1:0]     frame_one_ff, frame_zero_ff;
   logic [lcpfe_pkg::PAD_WIDTH-1:0]      frame_pad_ff;
   logic [lcpfe_pkg::DUTY_WIDTH-1:0]     duty_ff, duty_in;
   logic                                 last_ff;
   logic [lcpfe_pkg::BITS_PER_PIXEL-1:0] color;
   logic [lcpfe_pkg::BITS_PER_PIXEL-1:0] word;
   logic [lcpfe_pkg::BIT_CNT_WIDTH-1:0]  bit_pos;
   logic                                 index_ok;
   logic                                 csr_write;
   logic [lcpfe_pkg::CSR_IDX_WIDTH-1:0]  csr_idx;

   // green:red:blue, green sent first
   assign color    = {req_green, req_red, req_blue};
   assign index_ok = {1'b0, req_pixel_index} < 9'(lcpfe_pkg::CHAIN_LENGTH);

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx   = csr_paddr[lcpfe_pkg::CSR_ADDR_WIDTH-1:2];

   always_comb begin
      case (csr_idx)
         lcpfe_pkg::REG_ONE_BIT_DUTY:  csr_prdata = {16'd0, one_duty_ff};
         lcpfe_pkg::REG_ZERO_BIT_DUTY: csr_prdata = {16'd0, zero_duty_ff};
         lcpfe_pkg::REG_RESET_SLOTS:   csr_prdata = {24'd0, pad_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= lcpfe_pkg::ONE_BIT_DUTY_RESET;
         zero_duty_ff <= lcpfe_pkg::ZERO_BIT_DUTY_RESET;
         pad_ff       <= lcpfe_pkg::RESET_SLOTS_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            lcpfe_pkg::REG_ONE_BIT_DUTY:  one_duty_ff  <= csr_pwdata[15:0];
            lcpfe_pkg::REG_ZERO_BIT_DUTY: zero_duty_ff <= csr_pwdata[15:0];
            lcpfe_pkg::REG_RESET_SLOTS:   pad_ff       <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Snapshot of the registers for the frame in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_one_ff  <= lcpfe_pkg::ONE_BIT_DUTY_RESET;
         frame_zero_ff <= lcpfe_pkg::ZERO_BIT_DUTY_RESET;
         frame_pad_ff  <= lcpfe_pkg::RESET_SLOTS_RESET;
      end else if (cmd.frame_start) begin
         frame_one_ff  <= one_duty_ff;
         frame_zero_ff <= zero_duty_ff;
         frame_pad_ff  <= pad_ff;
      end
   end

   assign sts.cfg_pad   = pad_ff;
   assign sts.frame_pad = frame_pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lcpfe_pkg::CHAIN_LENGTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (cmd.store_write_all) begin
         for (int i = 0; i < lcpfe_pkg::CHAIN_LENGTH; i++) begin
            store_ff[i] <= color;
         end
      end else if (cmd.store_write_one && index_ok) begin
         store_ff[req_pixel_index[lcpfe_pkg::PIX_IDX_WIDTH-1:0]] <= color;
      end
   end

   // MSB of green first
   assign word    = store_ff[cmd.pix_sel];
   assign bit_pos = lcpfe_pkg::BIT_CNT_WIDTH'(lcpfe_pkg::BITS_PER_PIXEL - 1) - cmd.bit_sel;

   always_comb begin
      if (cmd.out_zero) begin
         duty_in = '0;
      end else if (word[bit_pos]) begin
         duty_in = frame_one_ff;
      end else begin
         duty_in = frame_zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         duty_ff <= duty_in;
         last_ff <= cmd.out_last;
      end
   end

   assign rsp_duty      = duty_ff;
   assign rsp_last_slot = last_ff;

endmodule

FILE: design/led_chain_pwm_frame_encoder.sv
// Top level of the LED chain PWM frame encoder: channels, register port, checks.
// Depends on lcpfe_pkg, lcpfe_if, lcpfe_ctrl and lcpfe_datapath.
`timescale 1ns / 1ps

// Serial LED chain encoder, GRB order, MSB first. Request transactions write one
// pixel, write every pixel, start a frame or tick one PWM slot. A frame is
// reset_slots zero slots, then 24 data slots per pixel (one_bit_duty or
// zero_bit_duty per bit), then reset_slots zero slots: 2*reset_slots + 24*16
// ticks in all, the last flagged by last_slot. One request transaction may be
// accepted every cycle while the response register is empty or being taken; a
// tick's slot shows up in the response register on the next cycle. This comes
// from the controller's registered pad, pixel and bit counters plus one read of
// the flip-flop pixel store, which reset clears. Pixel writes during a frame
// are dropped, a start during a frame restarts it, and the duties and pad
// length in effect are those captured at frame start.
// Registers: 0x0 one_bit_duty, 0x4 zero_bit_duty, 0x8 reset_slots.

module led_chain_pwm_frame_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   lcpfe_req_if.sink                            req_chan,
   lcpfe_rsp_if.source                          rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lcpfe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lcpfe_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lcpfe_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   lcpfe_pkg::cmd_type cmd;
   lcpfe_pkg::sts_type sts;
   logic               req_accept;
   logic               tick_accept;

   // register port never stalls
   assign csr_pready = 1'b1;

   assign req_accept  = req_chan.valid && req_chan.ready;
   assign tick_accept = req_accept && (req_chan.mode == lcpfe_pkg::MODE_TICK);

   lcpfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcpfe_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_pixel_index (req_chan.pixel_index),
      .req_red         (req_chan.red),
      .req_green       (req_chan.green),
      .req_blue        (req_chan.blue),
      .rsp_duty        (rsp_chan.duty),
      .rsp_last_slot   (rsp_chan.last_slot),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata)
   );

   // A slot is produced only for an accepted tick transaction.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> tick_accept)
      else $error("slot produced without an accepted tick");

   // After the final slot the frame is over: a following tick yields nothing.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) ##1 tick_accept |-> !cmd.out_load)
      else $error("slot produced after the final slot of the frame");

   // A taken response with nothing new behind it empties the output register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !cmd.out_load) |=> !rsp_chan.valid)
      else $error("response repeated after being taken");

   // At most one datapath action per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.store_write_one, cmd.store_write_all, cmd.frame_start, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule
